FILE: hdl/assert_macros.svh
// Assertion macros shared by the positional byte list RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hdl/pbl_pkg.sv
// Types and constants of the positional byte list.
// No dependencies.
`timescale 1ns / 1ps
package pbl_pkg;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 9;
  localparam int DATA_W = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 9;
  localparam int MEM_AW_MAX = 12;

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic                  we;
    logic [MEM_AW_MAX-1:0] waddr;
    logic [DATA_W-1:0]     wdata;
    logic [MEM_AW_MAX-1:0] raddr;
  } pbl_mem_req_t;
endpackage

FILE: hdl/pbl_req_if.sv
// Request channel of the positional byte list.
// Depends on pbl_pkg.
`timescale 1ns / 1ps
interface pbl_req_if import pbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output func, output position, output data_in, input ready);
  modport sink   (input valid, input func, input position, input data_in, output ready);
endinterface

FILE: hdl/pbl_rsp_if.sv
// Result channel of the positional byte list.
// Depends on pbl_pkg.
`timescale 1ns / 1ps
interface pbl_rsp_if import pbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output data_out, output status, output length, input ready);
  modport sink   (input valid, input data_out, input status, input length, output ready);
endinterface

FILE: hdl/pbl_store.sv
// Element store: one write port, one read port, registered read data.
// Depends on pbl_pkg.
`timescale 1ns / 1ps
module pbl_store import pbl_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  pbl_mem_req_t      mem_req,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
    rdata <= mem[mem_req.raddr[AW-1:0]];
  end
endmodule

FILE: hdl/positional_byte_list_unit.sv
// Positional byte list: sequencer around the element store.
// Depends on pbl_pkg, pbl_req_if, pbl_rsp_if, pbl_store, assert_macros.svh.
//
//   channel  dir  word
//   req      in   func, position, data_in
//   rsp      out  data_out, status, length
//
// Errors, set and push into an empty list: the result is registered at acceptance.
// Get: through S_GET. Insert/push: S_SHUP, then S_INS; delete: S_DEL, then S_SHDN
// while elements follow. Elements move one per cycle through the store's port pair.
// One word in flight; req is taken while idle and the result register is free
// or being emptied. Synchronous reset empties the list; no store clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module positional_byte_list_unit import pbl_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input logic    clk,
  input logic    rst,
  pbl_req_if.sink   req,
  pbl_rsp_if.source rsp
);
  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CW1 = CW + 1;
  localparam int XW  = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GET  = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DEL  = 3'd4;
  localparam logic [2:0] S_SHDN = 3'd5;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     k, k_next;
  logic [AW-1:0]     at, at_next;
  logic [DATA_W-1:0] val, val_next;
  logic              out_valid, out_valid_next;
  logic [DATA_W-1:0] out_data, out_data_next;
  logic [STAT_W-1:0] out_status, out_status_next;

  pbl_mem_req_t      mem_req;
  logic [DATA_W-1:0] rdata;

  logic              fire, full, empty, pos_ok;
  logic [XW-1:0]     pos_x, cnt_x;
  logic [AW-1:0]     at_req, k_m1;
  logic [CW1-1:0]    cnt_w;
  logic [CW+LEN_W-1:0] len_ext;

  pbl_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign fire      = req.valid && req.ready;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign pos_x     = XW'(req.position);
  assign cnt_x     = XW'(count);
  assign pos_ok    = (pos_x != '0) && (pos_x <= cnt_x);
  assign at_req    = AW'(req.position - 1'b1);
  assign k_m1      = k - 1'b1;
  assign cnt_w     = CW1'(count);
  assign len_ext   = {{LEN_W{1'b0}}, count};

  assign rsp.valid    = out_valid;
  assign rsp.data_out = out_data;
  assign rsp.status   = out_status;
  assign rsp.length   = len_ext[LEN_W-1:0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    k_next          = k;
    at_next         = at;
    val_next        = val;
    out_valid_next  = out_valid && !rsp.ready;
    out_data_next   = out_data;
    out_status_next = out_status;
    mem_req         = '0;

    unique case (state)
      S_IDLE: begin
        if (fire) begin
          out_data_next   = '0;
          out_status_next = ST_OK;
          val_next        = req.data_in;
          if (req.func == FUNC_PUSH) begin
            at_next = '0;
            if (full) begin
              out_valid_next  = 1'b1;
              out_status_next = ST_FULL;
            end else if (empty) begin
              mem_req.we     = 1'b1;
              mem_req.waddr  = '0;
              mem_req.wdata  = req.data_in;
              count_next     = count + 1'b1;
              out_valid_next = 1'b1;
            end else begin
              mem_req.raddr = MEM_AW_MAX'(count - 1'b1);
              k_next        = AW'(count);
              state_next    = S_SHUP;
            end
          end else if (req.func > FUNC_DELETE) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_BADPOS;
          end else if (empty) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_EMPTY;
          end else if (!pos_ok) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_BADPOS;
          end else begin
            at_next = at_req;
            case (req.func)
              FUNC_INSERT: begin
                if (full) begin
                  out_valid_next  = 1'b1;
                  out_status_next = ST_FULL;
                end else begin
                  mem_req.raddr = MEM_AW_MAX'(count - 1'b1);
                  k_next        = AW'(count);
                  state_next    = S_SHUP;
                end
              end
              FUNC_GET: begin
                mem_req.raddr = MEM_AW_MAX'(at_req);
                state_next    = S_GET;
              end
              FUNC_SET: begin
                mem_req.we     = 1'b1;
                mem_req.waddr  = MEM_AW_MAX'(at_req);
                mem_req.wdata  = req.data_in;
                out_valid_next = 1'b1;
              end
              default: begin
                mem_req.raddr = MEM_AW_MAX'(at_req);
                state_next    = S_DEL;
              end
            endcase
          end
        end
      end
      S_GET: begin
        out_valid_next = 1'b1;
        out_data_next  = rdata;
        state_next     = S_IDLE;
      end
      S_SHUP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MEM_AW_MAX'(k);
        mem_req.wdata = rdata;
        if (k_m1 != at) begin
          mem_req.raddr = MEM_AW_MAX'(k_m1 - 1'b1);
          k_next        = k_m1;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        mem_req.we     = 1'b1;
        mem_req.waddr  = MEM_AW_MAX'(at);
        mem_req.wdata  = val;
        count_next     = count + 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      S_DEL: begin
        val_next = rdata;
        if ((CW1'(at) + 1'b1) < cnt_w) begin
          mem_req.raddr = MEM_AW_MAX'(at) + 1'b1;
          k_next        = at;
          state_next    = S_SHDN;
        end else begin
          count_next     = count - 1'b1;
          out_valid_next = 1'b1;
          out_data_next  = rdata;
          state_next     = S_IDLE;
        end
      end
      S_SHDN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MEM_AW_MAX'(k);
        mem_req.wdata = rdata;
        if ((CW1'(k) + 2'd2) < cnt_w) begin
          mem_req.raddr = MEM_AW_MAX'(k) + 2'd2;
          k_next        = k + 1'b1;
        end else begin
          count_next     = count - 1'b1;
          out_valid_next = 1'b1;
          out_data_next  = val;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    k          <= k_next;
    at         <= at_next;
    val        <= val_next;
    out_data   <= out_data_next;
    out_status <= out_status_next;
  end

  `ASSERT_CLK(a_count_cap, count <= CW'(CAPACITY), "element count above capacity")
  `ASSERT_CLK(a_ready_idle, req.ready |-> (state == S_IDLE), "request taken while busy")
  `ASSERT_NEVER(a_busy_result, (state != S_IDLE) && out_valid, "result pending during op")
  `ASSERT_CLK(a_wr_bound, mem_req.we |-> (CW1'(mem_req.waddr) <= cnt_w), "write past list end")
  `ASSERT_CLK(a_len_step, (state == S_INS) |=> (count == $past(count) + 1'b1), "insert length")
endmodule

FILE: bench/tb_top.sv
// Self-checking bench for positional_byte_list_unit: directed table, then phased random traffic.
// A mirrored byte queue predicts every result word the table does not give. Bursty request side, stalling result side.
// Depends on pbl_pkg, pbl_req_if, pbl_rsp_if and the RTL of the list unit.
`timescale 1ns / 1ps
module tb_top import pbl_pkg::*; ();

  localparam int LIST_CAP = 256;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;
  localparam int RANDOM_WORDS = 1600;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
  } list_word_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
    logic              typed;
    list_word_t        want;
  } script_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{FUNC_GET,       9'd1,   8'h00, 1'b1, '{8'h00, ST_EMPTY,  9'd0}},
    '{FUNC_INSERT,    9'd1,   8'h3c, 1'b1, '{8'h00, ST_EMPTY,  9'd0}},
    '{FUNC_SET,       9'd1,   8'h3c, 1'b1, '{8'h00, ST_EMPTY,  9'd0}},
    '{FUNC_DELETE,    9'd1,   8'h00, 1'b1, '{8'h00, ST_EMPTY,  9'd0}},
    '{FUNC_UNUSED_HI, 9'd0,   8'h00, 1'b1, '{8'h00, ST_BADPOS, 9'd0}},
    '{FUNC_PUSH,      9'd0,   8'hff, 1'b1, '{8'h00, ST_OK,     9'd1}},
    '{FUNC_PUSH,      9'd511, 8'h00, 1'b1, '{8'h00, ST_OK,     9'd2}},
    '{FUNC_GET,       9'd0,   8'h00, 1'b1, '{8'h00, ST_BADPOS, 9'd2}},
    '{FUNC_GET,       9'd3,   8'h00, 1'b1, '{8'h00, ST_BADPOS, 9'd2}},
    '{FUNC_GET,       9'd511, 8'h00, 1'b1, '{8'h00, ST_BADPOS, 9'd2}},
    '{FUNC_GET,       9'd1,   8'hff, 1'b1, '{8'h00, ST_OK,     9'd2}},
    '{FUNC_GET,       9'd2,   8'h00, 1'b1, '{8'hff, ST_OK,     9'd2}},
    '{FUNC_INSERT,    9'd2,   8'ha5, 1'b1, '{8'h00, ST_OK,     9'd3}},
    '{FUNC_INSERT,    9'd4,   8'hc3, 1'b1, '{8'h00, ST_BADPOS, 9'd3}},
    '{FUNC_INSERT,    9'd1,   8'h81, 1'b0, '{8'h00, ST_OK,     9'd0}},
    '{FUNC_SET,       9'd4,   8'h5a, 1'b1, '{8'h00, ST_OK,     9'd4}},
    '{FUNC_GET,       9'd4,   8'h00, 1'b1, '{8'h5a, ST_OK,     9'd4}},
    '{FUNC_UNUSED_LO, 9'd1,   8'hff, 1'b1, '{8'h00, ST_BADPOS, 9'd4}},
    '{FUNC_DELETE,    9'd4,   8'h00, 1'b1, '{8'h5a, ST_OK,     9'd3}},
    '{FUNC_DELETE,    9'd5,   8'h00, 1'b1, '{8'h00, ST_BADPOS, 9'd3}},
    '{FUNC_DELETE,    9'd1,   8'h00, 1'b0, '{8'h00, ST_OK,     9'd0}},
    '{FUNC_DELETE,    9'd2,   8'h00, 1'b0, '{8'h00, ST_OK,     9'd0}},
    '{FUNC_DELETE,    9'd1,   8'h00, 1'b1, '{8'h00, ST_OK,     9'd0}},
    '{FUNC_DELETE,    9'd1,   8'h00, 1'b1, '{8'h00, ST_EMPTY,  9'd0}},
    '{FUNC_PUSH,      9'd0,   8'h7e, 1'b0, '{8'h00, ST_OK,     9'd0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pbl_req_if req();
  pbl_rsp_if rsp();

  positional_byte_list_unit #(.CAPACITY(LIST_CAP)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [DATA_W-1:0] list_mirror[$];
  list_word_t        awaited_words[$];
  list_word_t        oldest_word;
  int                word_faults = 0;
  int                burst_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Applies one request to the mirror and returns the word it should produce.
  function automatic list_word_t mirror_apply(input logic [FUNC_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [DATA_W-1:0] data);
    list_word_t w;
    int n;
    int idx;
    n = list_mirror.size();
    idx = int'(pos) - 1;
    w = '{data_out: '0, status: ST_OK, length: '0};
    case (op) inside
      FUNC_PUSH: begin
        if (n >= LIST_CAP) w.status = ST_FULL;
        else list_mirror.push_front(data);
      end
      FUNC_INSERT, FUNC_GET, FUNC_SET, FUNC_DELETE: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
        end else if (pos < 1 || int'(pos) > n) begin
          w.status = ST_BADPOS;
        end else begin
          case (op)
            FUNC_INSERT: begin
              if (n >= LIST_CAP) w.status = ST_FULL;
              else list_mirror.insert(idx, data);
            end
            FUNC_GET: w.data_out = list_mirror[idx];
            FUNC_SET: list_mirror[idx] = data;
            default: begin
              w.data_out = list_mirror[idx];
              list_mirror.delete(idx);
            end
          endcase
        end
      end
      default: w.status = ST_BADPOS;
    endcase
    w.length = LEN_W'(list_mirror.size());
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic put_word(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [DATA_W-1:0] data, input logic typed,
                          input list_word_t want);
    int gap;
    list_word_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) gap = 0;
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req.valid    <= 1'b1;
    req.func     <= op;
    req.position <= pos;
    req.data_in  <= data;
    do @(posedge clk); while (!req.ready);
    predicted = mirror_apply(op, pos, data);
    awaited_words.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_position(input int n);
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return '0;
      1: return POS_W'(n + 1);
      2: return POS_W'($urandom_range(0, 511));
      3: return POS_W'(n);
      4: return POS_W'(1);
      default: return POS_W'($urandom_range(1, (n > 0) ? n : 1));
    endcase
  endfunction

  initial begin
    rx_mode_t mode;
    int left;
    int k;
    rsp.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    k = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
        k = 0;
      end
      left--;
      k++;
      case (mode)
        RX_OPEN:   rsp.ready <= 1'b1;
        RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: rsp.ready <= (k % 4 == 0);
        default:   rsp.ready <= (k % 13 >= 8);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_words.size() == 0) begin
        $error("result word with none awaited: data_out %0h status %0d length %0d",
               rsp.data_out, rsp.status, rsp.length);
        word_faults++;
      end else begin
        oldest_word = awaited_words.pop_front();
        if (rsp.data_out !== oldest_word.data_out) begin
          $error("data_out: expected %0h, actual %0h", oldest_word.data_out, rsp.data_out);
          word_faults++;
        end
        if (rsp.status !== oldest_word.status) begin
          $error("status: expected %0d, actual %0d", oldest_word.status, rsp.status);
          word_faults++;
        end
        if (rsp.length !== oldest_word.length) begin
          $error("length: expected %0d, actual %0d", oldest_word.length, rsp.length);
          word_faults++;
        end
      end
    end
  end

  initial begin
    int n;
    int goal;
    int settle;
    int roll;
    int pick;
    logic [FUNC_W-1:0] op;
    req.valid    = 1'b0;
    req.func     = FUNC_PUSH;
    req.position = '0;
    req.data_in  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      put_word(SCRIPT[i].op, SCRIPT[i].pos, SCRIPT[i].data, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // Phases steer the length toward a goal: empty, full, short or anywhere.
    goal = LIST_CAP;
    settle = $urandom_range(4, 24);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      n = list_mirror.size();
      if (n == goal) begin
        if (settle == 0) begin
          pick = $urandom_range(0, 9);
          goal = (pick < 2) ? 0 :
                 (pick < 4) ? LIST_CAP :
                 (pick < 8) ? $urandom_range(1, 16) : $urandom_range(0, LIST_CAP);
          settle = $urandom_range(4, 24);
        end else begin
          settle--;
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        op = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
      end else if (n < goal) begin
        op = (roll < 45) ? FUNC_PUSH : (roll < 85) ? FUNC_INSERT :
             (roll < 90) ? FUNC_DELETE : (roll < 95) ? FUNC_GET : FUNC_SET;
      end else if (n > goal) begin
        op = (roll < 70) ? FUNC_DELETE : (roll < 80) ? FUNC_GET :
             (roll < 90) ? FUNC_SET : (roll < 95) ? FUNC_PUSH : FUNC_INSERT;
      end else begin
        op = FUNC_W'($urandom_range(FUNC_PUSH, FUNC_DELETE));
      end
      put_word(op, pick_position(n), DATA_W'($urandom_range(0, 255)), 1'b0, '0);
    end

    req.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (word_faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
